// ===== src/mcmp_pkg.sv =====
// types and constants shared by the midi channel message parser
// no dependencies

package mcmp_pkg;

    typedef enum logic [2:0] {
        KIND_NOTE_OFF = 3'd0,
        KIND_NOTE_ON  = 3'd1,
        KIND_CC       = 3'd2,
        KIND_PROGRAM  = 3'd3,
        KIND_BEND     = 3'd4
    } t_event_kind;

    // upper nibble of a status byte
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_CC       = 4'hB;
    localparam logic [3:0] STAT_PROGRAM  = 4'hC;
    localparam logic [3:0] STAT_PRESSURE = 4'hD;
    localparam logic [3:0] STAT_BEND     = 4'hE;

    localparam logic [7:0] REALTIME_MIN  = 8'hF8;
    localparam logic [7:0] NO_STATUS     = 8'h00;

    localparam logic [1:0] CNT_ZERO      = 2'd0;
    localparam logic [1:0] CNT_ONE       = 2'd1;
    localparam logic [1:0] CNT_TWO       = 2'd2;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] first_data;
        logic [1:0] expected;
        logic       have_first;
    } t_parse_state;

    typedef struct packed {
        t_event_kind kind;
        logic [3:0]  channel;
        logic [6:0]  key;
        logic [6:0]  amount;
        logic [13:0] bend;
    } t_event;

endpackage

// ===== src/mcmp_decode.sv =====
// per-byte decode: next parse state and the event a completed message gives
// depends on mcmp_pkg

module mcmp_decode (
    input  mcmp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_start,
    output mcmp_pkg::t_parse_state o_state,
    output logic                   o_emit,
    output mcmp_pkg::t_event       o_evt
);
    import mcmp_pkg::*;

    t_parse_state st;
    logic         complete;
    logic [6:0]   d1;
    logic [6:0]   d2;

    always_comb begin
        st       = i_start ? '0 : i_state;
        o_state  = st;
        complete = 1'b0;
        d1       = i_byte[6:0];
        d2       = '0;
        if (i_byte >= REALTIME_MIN) begin
            o_state = st;
        end else if (i_byte[7]) begin
            o_state.status     = i_byte;
            o_state.first_data = '0;
            o_state.have_first = 1'b0;
            case (i_byte[7:4])
                STAT_PROGRAM:  o_state.expected = CNT_ONE;
                STAT_PRESSURE: o_state.expected = CNT_ZERO;
                default:       o_state.expected = CNT_TWO;
            endcase
        end else if (st.status == NO_STATUS) begin
            o_state = st;
        end else if (st.expected == CNT_ONE) begin
            o_state  = '0;
            complete = 1'b1;
        end else if (st.expected == CNT_TWO && !st.have_first) begin
            o_state.first_data = i_byte[6:0];
            o_state.have_first = 1'b1;
        end else begin
            o_state  = '0;
            complete = 1'b1;
            d1       = st.first_data;
            d2       = i_byte[6:0];
        end
    end

    always_comb begin
        o_evt.kind    = KIND_NOTE_OFF;
        o_evt.channel = st.status[3:0];
        o_evt.key     = d1;
        o_evt.amount  = d2;
        o_evt.bend    = '0;
        o_emit        = complete;
        case (st.status[7:4])
            STAT_NOTE_ON:  o_evt.kind = (d2 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            STAT_NOTE_OFF: o_evt.kind = KIND_NOTE_OFF;
            STAT_CC:       o_evt.kind = KIND_CC;
            STAT_PROGRAM: begin
                o_evt.kind   = KIND_PROGRAM;
                o_evt.amount = '0;
            end
            STAT_BEND: begin
                o_evt.kind   = KIND_BEND;
                o_evt.bend   = {d2, d1};
                o_evt.key    = '0;
                o_evt.amount = '0;
            end
            default: o_emit = 1'b0;
        endcase
    end

endmodule

// ===== src/mcmp_out_reg.sv =====
// output register holding one decoded event until the sink takes it
// depends on mcmp_pkg

module mcmp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_emit,
    input  mcmp_pkg::t_event  i_evt,
    input  logic              i_out_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output mcmp_pkg::t_event  o_evt
);
    import mcmp_pkg::*;

    logic   r_valid;
    t_event r_evt;

    assign o_can_load = !r_valid || i_out_ready;
    assign o_valid    = r_valid;
    assign o_evt      = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_push && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_push && i_emit) begin
            r_evt <= i_evt;
        end
    end

endmodule

// ===== src/midi_channel_message_parser.sv =====
// midi channel message parser: one received byte per item, channel events out
// path: a message's last byte is held in the input register, decoded, and its event registered in the output register
// throughput: one byte per cycle while the output register can load, set by the input register and the output register
// reset clears the parse state and both valid flags; no clearing pass
// depends on mcmp_pkg, mcmp_decode, mcmp_out_reg

module midi_channel_message_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // midi_byte
    input  logic        s_axis_tuser,   // buffer_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // channel, key, amount, bend
    output logic [2:0]  m_axis_tuser    // event_kind
);
    import mcmp_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_start;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         dec_emit;
    t_event       dec_evt;
    t_event       out_evt;
    logic         can_load;
    logic         advance;

    assign advance       = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    mcmp_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_state (n_state),
        .o_emit  (dec_emit),
        .o_evt   (dec_evt)
    );

    mcmp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (advance),
        .i_emit      (dec_emit),
        .i_evt       (dec_evt),
        .i_out_ready (m_axis_tready),
        .o_can_load  (can_load),
        .o_valid     (m_axis_tvalid),
        .o_evt       (out_evt)
    );

    assign m_axis_tdata = {out_evt.bend, out_evt.amount, out_evt.key, out_evt.channel};
    assign m_axis_tuser = out_evt.kind;

endmodule
